>>> rtl/core/tmtp_pkg.sv
package tmtp_pkg;

   // Field widths
   localparam int TICKET_W   = 16;
   localparam int DRAW_W     = 16;
   localparam int TOTAL_W    = 20;
   localparam int PRIO_W     = 8;
   localparam int INDEX_W    = 4;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam int DEF_MAX_THREADS = 16;

   localparam logic [TICKET_W-1:0] TICKET_MAX = {TICKET_W{1'b1}};
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

   // Scheduling modes
   localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOTTERY     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIORITY    = 2'd2;

   // Request functions
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THREAD_COUNT = 1'd1;

   typedef struct packed {
      logic                func;
      logic [INDEX_W-1:0]  thread_index;
      logic                thread_alive;
      logic [PRIO_W-1:0]   thread_priority;
      logic [TICKET_W-1:0] thread_tickets;
      logic [DRAW_W-1:0]   random_draw;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] chosen_thread;
      logic               choice_valid;
   } rsp_type;

   // One thread table entry held in memory
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [TICKET_W-1:0] tickets;
   } entry_type;

endpackage

>>> rtl/core/tmtp_table.sv
module tmtp_table #(
   parameter int MAX_THREADS = tmtp_pkg::DEF_MAX_THREADS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(MAX_THREADS)-1:0] rd_addr,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_THREADS)-1:0] wr_addr,
   input  tmtp_pkg::entry_type            wr_data,
   output tmtp_pkg::entry_type            rd_data
);

   tmtp_pkg::entry_type entry_mem_ff [MAX_THREADS];
   tmtp_pkg::entry_type rd_data_ff;
   logic [MAX_THREADS-1:0] vld_ff;
   logic                   rd_vld_ff;

   // Write the entry; the read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   // Track written entries; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> rtl/core/tmtp_modulo.sv
module tmtp_modulo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmtp_pkg::DRAW_W-1:0]   dividend,
   input  logic [tmtp_pkg::TOTAL_W:0]    divisor,
   output logic                          done,
   output logic [tmtp_pkg::TOTAL_W-1:0]  remainder
);

   localparam int DIV_W = tmtp_pkg::TOTAL_W + 1;
   localparam int CNT_W = $clog2(tmtp_pkg::DRAW_W);

   logic [tmtp_pkg::DRAW_W-1:0] dvd_ff;
   logic [DIV_W-1:0]            dsr_ff;
   logic [DIV_W-1:0]            rem_ff;
   logic [DIV_W-1:0]            rem_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [DIV_W:0]              shifted;
   logic [DIV_W:0]              diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[tmtp_pkg::DRAW_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = diff[DIV_W-1:0];
      end else begin
         rem_in = shifted[DIV_W-1:0];
      end
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(tmtp_pkg::DRAW_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Hold operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[tmtp_pkg::DRAW_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[tmtp_pkg::TOTAL_W-1:0];

endmodule

>>> rtl/core/three_mode_thread_picker.sv
// Timing: each table read passes the registered table memory port, and a lottery tick
//   waits on the 16-step serial modulo unit. One transaction is in work at a time.
// Reset: synchronous; clears control state, marks and ticket total; mode is round-robin,
//   thread count one. Table entries read as zero until written; there is no clearing pass.
module three_mode_thread_picker #(
   parameter int MAX_THREADS = tmtp_pkg::DEF_MAX_THREADS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tmtp_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tmtp_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tmtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tmtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SLOT_W  = $clog2(MAX_THREADS);
   localparam int CNT_W   = $clog2(MAX_THREADS + 1);
   localparam int TOTAL_W = tmtp_pkg::TOTAL_W;
   localparam int WIDE_W  = 8;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_WR_UPD  = 12'b0000_0000_0010,
      S_RR_MOD  = 12'b0000_0000_0100,
      S_WALK    = 12'b0000_0000_1000,
      S_LOT_DIV = 12'b0000_0001_0000,
      S_LOT_RD  = 12'b0000_0010_0000,
      S_LOT_CHK = 12'b0000_0100_0000,
      S_PRI_RD  = 12'b0000_1000_0000,
      S_PRI_CHK = 12'b0001_0000_0000,
      S_PRI_CLR = 12'b0010_0000_0000,
      S_DONE    = 12'b0100_0000_0000,
      S_SPARE   = 12'b1000_0000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [tmtp_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [tmtp_pkg::COUNT_W-1:0]      tcount_ff, tcount_in;
   logic [CNT_W-1:0]                  n_ff, n_in;
   logic [CNT_W-1:0]                  pos_ff, pos_in;
   logic [TOTAL_W-1:0]                left_ff, left_in;
   logic [SLOT_W-1:0]                 best_ff, best_in;
   logic [tmtp_pkg::PRIO_W-1:0]       bestp_ff, bestp_in;
   logic                              found_ff, found_in;
   logic                              retried_ff, retried_in;
   logic [SLOT_W-1:0]                 pick_ff, pick_in;
   logic                              pick_valid_ff, pick_valid_in;
   logic [SLOT_W-1:0]                 cur_ff, cur_in;
   logic [TOTAL_W-1:0]                total_ff, total_in;
   logic [MAX_THREADS-1:0]            alive_ff, alive_in;
   logic [MAX_THREADS-1:0]            ran_ff, ran_in;
   tmtp_pkg::req_type                 item_ff, item_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   tmtp_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic [SLOT_W-1:0]                 tbl_rd_addr;
   logic                              tbl_wr_en;
   logic [SLOT_W-1:0]                 tbl_wr_addr;
   tmtp_pkg::entry_type               tbl_wr_data;
   tmtp_pkg::entry_type               tbl_rd_data;

   logic                              div_start;
   logic                              div_done;
   logic [TOTAL_W-1:0]                div_rem;

   logic [WIDE_W-1:0]                 tc_wide;
   logic [CNT_W-1:0]                  n_calc;
   logic [MAX_THREADS-1:0]            mask_calc;
   logic [MAX_THREADS-1:0]            mask_ff;
   logic                              any_alive;
   logic [SLOT_W-1:0]                 pos_slot;
   logic                              pos_last;
   logic [CNT_W-1:0]                  pos_inc;
   logic [CNT_W-1:0]                  pos_wrap;
   logic [WIDE_W-1:0]                 req_idx_wide;
   logic [WIDE_W-1:0]                 item_idx_wide;
   logic [SLOT_W-1:0]                 item_slot;
   logic                              item_idx_ok;
   logic [TOTAL_W-1:0]                tk_wide;
   logic                              cand;
   logic [WIDE_W-1:0]                 pick_wide;
   logic                              req_fire;

   tmtp_table #(
      .MAX_THREADS(MAX_THREADS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (tbl_rd_addr),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   tmtp_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_payload.random_draw),
      .divisor   ({1'b0, total_ff} + (TOTAL_W + 1)'(1)),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Clamp the slot count and mask the slots in use
   always_comb begin
      tc_wide = {{(WIDE_W - tmtp_pkg::COUNT_W){1'b0}}, tcount_ff};
      if (tc_wide == '0) begin
         n_calc = CNT_W'(1);
      end else if (tc_wide > WIDE_W'(MAX_THREADS)) begin
         n_calc = CNT_W'(MAX_THREADS);
      end else begin
         n_calc = tc_wide[CNT_W-1:0];
      end
      for (int i = 0; i < MAX_THREADS; i++) begin
         mask_calc[i] = (i < int'(n_calc));
         mask_ff[i]   = (i < int'(n_ff));
      end
      any_alive = |(alive_ff & mask_calc);
   end

   // Walk position helpers
   always_comb begin
      pos_slot      = pos_ff[SLOT_W-1:0];
      pos_last      = (pos_ff == n_ff - CNT_W'(1));
      pos_inc       = pos_ff + CNT_W'(1);
      pos_wrap      = (pos_inc == n_ff) ? '0 : pos_inc;
      req_idx_wide  = {{(WIDE_W - tmtp_pkg::INDEX_W){1'b0}}, req_payload.thread_index};
      item_idx_wide = {{(WIDE_W - tmtp_pkg::INDEX_W){1'b0}}, item_ff.thread_index};
      item_slot     = item_idx_wide[SLOT_W-1:0];
      item_idx_ok   = (int'(item_ff.thread_index) < MAX_THREADS);
      tk_wide       = {{(TOTAL_W - tmtp_pkg::TICKET_W){1'b0}}, tbl_rd_data.tickets};
      cand          = alive_ff[pos_slot] && !ran_ff[pos_slot]
                      && (!found_ff || (tbl_rd_data.prio > bestp_ff));
      pick_wide     = {{(WIDE_W - SLOT_W){1'b0}}, pick_ff};
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tcount_in     = tcount_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      best_in       = best_ff;
      bestp_in      = bestp_ff;
      found_in      = found_ff;
      retried_in    = retried_ff;
      pick_in       = pick_ff;
      pick_valid_in = pick_valid_ff;
      cur_in        = cur_ff;
      total_in      = total_ff;
      alive_in      = alive_ff;
      ran_in        = ran_ff;
      item_in       = item_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      tbl_rd_addr   = pos_slot;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = pos_slot;
      tbl_wr_data   = tbl_rd_data;
      div_start     = 1'b0;

      // Take register writes
      if (csr_valid) begin
         case (csr_index)
            tmtp_pkg::CSR_SCHED_MODE:   mode_in   = csr_wdata[tmtp_pkg::MODE_W-1:0];
            tmtp_pkg::CSR_THREAD_COUNT: tcount_in = csr_wdata[tmtp_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            tbl_rd_addr = req_idx_wide[SLOT_W-1:0];
            if (req_fire) begin
               item_in       = req_payload;
               n_in          = n_calc;
               pick_in       = '0;
               pick_valid_in = 1'b0;
               pos_in        = '0;
               found_in      = 1'b0;
               retried_in    = 1'b0;
               if (req_payload.func == tmtp_pkg::FUNC_WRITE) begin
                  state_in = S_WR_UPD;
               end else if (!any_alive) begin
                  state_in = S_DONE;
               end else begin
                  case (mode_ff)
                     tmtp_pkg::MODE_ROUND_ROBIN: begin
                        pos_in   = CNT_W'(cur_ff) + CNT_W'(1);
                        state_in = S_RR_MOD;
                     end
                     tmtp_pkg::MODE_LOTTERY: begin
                        div_start = 1'b1;
                        state_in  = S_LOT_DIV;
                     end
                     tmtp_pkg::MODE_PRIORITY: state_in = S_PRI_RD;
                     default:                 state_in = S_DONE;
                  endcase
               end
            end
         end

         // Replace the entry and adjust the ticket total
         S_WR_UPD: begin
            if (item_idx_ok) begin
               total_in            = total_ff - tk_wide
                                     + {{(TOTAL_W - tmtp_pkg::TICKET_W){1'b0}},
                                        item_ff.thread_tickets};
               tbl_wr_en           = 1'b1;
               tbl_wr_addr         = item_slot;
               tbl_wr_data.prio    = item_ff.thread_priority;
               tbl_wr_data.tickets = item_ff.thread_tickets;
               alive_in[item_slot] = item_ff.thread_alive;
               ran_in[item_slot]   = 1'b0;
            end
            state_in = S_DONE;
         end

         // Reduce the start slot into range
         S_RR_MOD: begin
            if (pos_ff >= n_ff) begin
               pos_in = pos_ff - n_ff;
            end else begin
               state_in = S_WALK;
            end
         end

         // Advance to the next alive slot, wrapping
         S_WALK: begin
            if (alive_ff[pos_slot]) begin
               pick_in       = pos_slot;
               pick_valid_in = 1'b1;
               cur_in        = pos_slot;
               state_in      = S_DONE;
            end else begin
               pos_in = pos_wrap;
            end
         end

         S_LOT_DIV: begin
            if (div_done) begin
               left_in  = div_rem;
               pos_in   = '0;
               state_in = S_LOT_RD;
            end
         end

         S_LOT_RD: state_in = S_LOT_CHK;

         // Subtract tickets; a passed loser gains one
         S_LOT_CHK: begin
            if (tk_wide >= left_ff) begin
               state_in = S_WALK;
            end else begin
               left_in = left_ff - tk_wide;
               if (tbl_rd_data.tickets != tmtp_pkg::TICKET_MAX) begin
                  tbl_wr_en           = 1'b1;
                  tbl_wr_data.tickets = tbl_rd_data.tickets + tmtp_pkg::TICKET_W'(1);
                  if (total_ff != tmtp_pkg::TOTAL_MAX) begin
                     total_in = total_ff + TOTAL_W'(1);
                  end
               end
               if (pos_last) begin
                  state_in = S_WALK;
               end else begin
                  pos_in   = pos_inc;
                  state_in = S_LOT_RD;
               end
            end
         end

         S_PRI_RD: state_in = S_PRI_CHK;

         // Track the best candidate, lowest index on ties
         S_PRI_CHK: begin
            if (cand) begin
               best_in  = pos_slot;
               bestp_in = tbl_rd_data.prio;
               found_in = 1'b1;
            end
            if (pos_last) begin
               if (found_ff || cand) begin
                  pick_in         = cand ? pos_slot : best_ff;
                  pick_valid_in   = 1'b1;
                  cur_in          = cand ? pos_slot : best_ff;
                  ran_in[pick_in] = 1'b1;
                  state_in        = S_DONE;
               end else if (!retried_ff) begin
                  state_in = S_PRI_CLR;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               pos_in   = pos_inc;
               state_in = S_PRI_RD;
            end
         end

         // Clear run marks of slots in use and retry once
         S_PRI_CLR: begin
            ran_in     = ran_ff & ~mask_ff;
            retried_in = 1'b1;
            found_in   = 1'b0;
            pos_in     = '0;
            state_in   = S_PRI_RD;
         end

         // Hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.chosen_thread  = pick_valid_ff ? pick_wide[tmtp_pkg::INDEX_W-1:0]
                                                          : '0;
               rsp_data_in.choice_valid   = pick_valid_ff;
               state_in                   = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= tmtp_pkg::MODE_ROUND_ROBIN;
         tcount_ff     <= tmtp_pkg::COUNT_W'(1);
         total_ff      <= '0;
         cur_ff        <= '0;
         alive_ff      <= '0;
         ran_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pick_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         retried_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         tcount_ff     <= tcount_in;
         total_ff      <= total_in;
         cur_ff        <= cur_in;
         alive_ff      <= alive_in;
         ran_ff        <= ran_in;
         rsp_valid_ff  <= rsp_valid_in;
         pick_valid_ff <= pick_valid_in;
         found_ff      <= found_in;
         retried_ff    <= retried_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      left_ff     <= left_in;
      best_ff     <= best_in;
      bestp_ff    <= bestp_in;
      pick_ff     <= pick_in;
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The ticket total moves only on a table write or a lottery step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WR_UPD && state_ff != S_LOT_CHK) |=> total_ff == $past(total_ff))
      else $error("ticket total changed outside a write or lottery step");

   // A run mark is set only when a priority pick is made
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PRI_CHK) |=> (ran_ff & ~$past(ran_ff)) == '0)
      else $error("run mark set outside priority pick");

   // A valid pick lies among the slots in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && pick_valid_ff) |-> CNT_W'(pick_ff) < n_ff)
      else $error("picked slot outside slots in use");

endmodule
